FILE: hw/rtl/updv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// updv_pkg
// Types and constants shared by the request path decoder and key checker.
// ----------------------------------------------------------------------------
package updv_pkg;

    // characters that steer the decoder
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_LA       = 8'h61;
    localparam logic [7:0] CH_LF       = 8'h66;
    localparam logic [7:0] CH_UA       = 8'h41;
    localparam logic [7:0] CH_UF       = 8'h46;
    localparam logic [7:0] HEX_TEN     = 8'd10;

    // segment length saturates here
    localparam logic [1:0] SEG_LEN_MAX = 2'd3;

    // escape progress: nothing held, '%' held, '%' and one hex digit held
    localparam logic [1:0] PEND_NONE = 2'd0;
    localparam logic [1:0] PEND_PCT  = 2'd1;
    localparam logic [1:0] PEND_HEX  = 2'd2;

    // end-of-key status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_EMPTY_KEY = 3'd1,
        ST_EMPTY_SEG = 3'd2,
        ST_DOT_SEG   = 3'd3,
        ST_NULL_BYTE = 3'd4
    } status_t;

    // one input transfer
    typedef struct packed {
        logic [7:0] target_byte;
        logic       last_byte;
    } item_t;

    // one result transfer
    typedef struct packed {
        logic [7:0] key_byte;
        logic       byte_valid;
        logic       end_of_key;
        logic [2:0] status;
    } res_t;

    // segment tracking of the decoded path
    typedef struct packed {
        logic       past_lead;
        logic [1:0] seg_len;
        logic       all_dots;
        status_t    first_err;
        logic       saw_null;
    } trk_t;

    // per-target control state (the held hex digit lives apart, unreset)
    typedef struct packed {
        logic       at_start;
        logic [7:0] skip_left;
        logic       in_query;
        logic [1:0] pend_cnt;
        trk_t       trk;
    } pst_t;

    localparam pst_t PST_RESET = '{
        at_start:  1'b1,
        skip_left: 8'd0,
        in_query:  1'b0,
        pend_cnt:  PEND_NONE,
        trk:       '{past_lead: 1'b0, seg_len: 2'd0, all_dots: 1'b1,
                     first_err: ST_OK, saw_null: 1'b0}
    };

    // results one byte can cause: up to three key bytes and the end result
    localparam int unsigned RES_MAX = 4;

endpackage
`default_nettype wire

FILE: hw/rtl/updv_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// updv_step
// Combinational work for one target byte: prefix skip, query cut-off,
// percent decoding, slash stripping, segment checks and result packing.
// ----------------------------------------------------------------------------
module updv_step (
    input  updv_pkg::item_t item,
    input  updv_pkg::pst_t  cur,
    input  logic [7:0]      pend_hex,
    input  logic [7:0]      skip_len,
    output updv_pkg::pst_t  nxt,
    output logic [7:0]      pend_hex_next,
    output updv_pkg::res_t  res [updv_pkg::RES_MAX],
    output logic [2:0]      res_cnt
);

    typedef struct packed {
        updv_pkg::trk_t s;
        logic           emit;
    } dlv_t;

    function automatic logic is_hex(logic [7:0] c);
        return ((c >= updv_pkg::CH_ZERO) && (c <= updv_pkg::CH_NINE)) ||
               ((c >= updv_pkg::CH_LA) && (c <= updv_pkg::CH_LF)) ||
               ((c >= updv_pkg::CH_UA) && (c <= updv_pkg::CH_UF));
    endfunction

    function automatic logic [3:0] hex_val(logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if ((c >= updv_pkg::CH_ZERO) && (c <= updv_pkg::CH_NINE))
            v = 4'(c - updv_pkg::CH_ZERO);
        else if ((c >= updv_pkg::CH_LA) && (c <= updv_pkg::CH_LF))
            v = 4'(c - updv_pkg::CH_LA + updv_pkg::HEX_TEN);
        else if ((c >= updv_pkg::CH_UA) && (c <= updv_pkg::CH_UF))
            v = 4'(c - updv_pkg::CH_UA + updv_pkg::HEX_TEN);
        return v;
    endfunction

    function automatic updv_pkg::trk_t close_seg(updv_pkg::trk_t s);
        updv_pkg::trk_t r;
        r = s;
        if (s.first_err == updv_pkg::ST_OK) begin
            if (s.seg_len == 2'd0)
                r.first_err = updv_pkg::ST_EMPTY_SEG;
            else if (s.all_dots && (s.seg_len != updv_pkg::SEG_LEN_MAX))
                r.first_err = updv_pkg::ST_DOT_SEG;
        end
        r.seg_len  = 2'd0;
        r.all_dots = 1'b1;
        return r;
    endfunction

    // one decoded path byte through slash stripping and segment tracking
    function automatic dlv_t deliver(updv_pkg::trk_t s, logic [7:0] b, logic en);
        dlv_t r;
        r.s    = s;
        r.emit = 1'b0;
        if (en && !(!s.past_lead && (b == updv_pkg::CH_SLASH))) begin
            r.emit        = 1'b1;
            r.s.past_lead = 1'b1;
            if (b == updv_pkg::CH_SLASH) begin
                r.s = close_seg(r.s);
            end
            else begin
                if (r.s.seg_len != updv_pkg::SEG_LEN_MAX)
                    r.s.seg_len = r.s.seg_len + 2'd1;
                if (b != updv_pkg::CH_DOT)
                    r.s.all_dots = 1'b0;
                if (b == updv_pkg::CH_NUL)
                    r.s.saw_null = 1'b1;
            end
        end
        return r;
    endfunction

    logic [7:0]     c;
    logic [7:0]     skip_eff;
    logic [7:0]     slot_byte [5];
    logic           slot_en   [5];
    logic           slot_emit [5];
    logic [1:0]     pend_mid;
    logic [7:0]     hex_mid;
    updv_pkg::pst_t ctl;
    updv_pkg::trk_t trk_end;
    dlv_t           d;
    logic [2:0]     n;
    logic [2:0]     st;

    assign c = item.target_byte;

    // byte classification and escape handling
    always_comb
    begin
        skip_eff = cur.at_start ? skip_len : cur.skip_left;
        ctl      = cur;
        ctl.at_start  = 1'b0;
        ctl.skip_left = skip_eff;
        pend_mid = cur.pend_cnt;
        hex_mid  = pend_hex;
        for (int i = 0; i < 5; i++)
        begin
            slot_byte[i] = c;
            slot_en[i]   = 1'b0;
        end
        slot_byte[3] = updv_pkg::CH_PERCENT;
        slot_byte[4] = pend_hex;

        if (!cur.in_query) begin
            if (c == updv_pkg::CH_QUESTION) begin
                ctl.in_query = 1'b1;
                slot_byte[0] = updv_pkg::CH_PERCENT;
                slot_en[0]   = (cur.pend_cnt != updv_pkg::PEND_NONE);
                slot_byte[1] = pend_hex;
                slot_en[1]   = (cur.pend_cnt == updv_pkg::PEND_HEX);
                pend_mid     = updv_pkg::PEND_NONE;
            end
            else if (skip_eff != 8'd0) begin
                ctl.skip_left = skip_eff - 8'd1;
            end
            else begin
                unique case (cur.pend_cnt)
                    updv_pkg::PEND_PCT:
                    begin
                        if (is_hex(c)) begin
                            hex_mid  = c;
                            pend_mid = updv_pkg::PEND_HEX;
                        end
                        else begin
                            slot_byte[0] = updv_pkg::CH_PERCENT;
                            slot_en[0]   = 1'b1;
                            slot_en[1]   = (c != updv_pkg::CH_PERCENT);
                            pend_mid     = (c == updv_pkg::CH_PERCENT) ?
                                           updv_pkg::PEND_PCT : updv_pkg::PEND_NONE;
                        end
                    end
                    updv_pkg::PEND_HEX:
                    begin
                        if (is_hex(c)) begin
                            slot_byte[0] = {hex_val(pend_hex), hex_val(c)};
                            slot_en[0]   = 1'b1;
                            pend_mid     = updv_pkg::PEND_NONE;
                        end
                        else begin
                            slot_byte[0] = updv_pkg::CH_PERCENT;
                            slot_en[0]   = 1'b1;
                            slot_byte[1] = pend_hex;
                            slot_en[1]   = 1'b1;
                            slot_en[2]   = (c != updv_pkg::CH_PERCENT);
                            pend_mid     = (c == updv_pkg::CH_PERCENT) ?
                                           updv_pkg::PEND_PCT : updv_pkg::PEND_NONE;
                        end
                    end
                    default:
                    begin
                        slot_en[0] = (c != updv_pkg::CH_PERCENT);
                        pend_mid   = (c == updv_pkg::CH_PERCENT) ?
                                     updv_pkg::PEND_PCT : updv_pkg::PEND_NONE;
                    end
                endcase
            end
        end

        // an escape still open at the last byte is flushed as literals
        slot_byte[4] = hex_mid;
        if (item.last_byte) begin
            slot_en[3] = (pend_mid != updv_pkg::PEND_NONE);
            slot_en[4] = (pend_mid == updv_pkg::PEND_HEX);
        end
        ctl.pend_cnt  = item.last_byte ? updv_pkg::PEND_NONE : pend_mid;
        pend_hex_next = hex_mid;
    end

    // deliver the decoded bytes in order and pack the results
    always_comb
    begin
        d.s    = cur.trk;
        d.emit = 1'b0;
        for (int i = 0; i < 5; i++)
        begin
            d            = deliver(d.s, slot_byte[i], slot_en[i]);
            slot_emit[i] = d.emit;
        end

        for (int i = 0; i < updv_pkg::RES_MAX; i++)
        begin
            res[i] = '{key_byte: 8'd0, byte_valid: 1'b0, end_of_key: 1'b0,
                       status: updv_pkg::ST_OK};
        end
        n = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (slot_emit[i]) begin
                res[n[1:0]].key_byte   = slot_byte[i];
                res[n[1:0]].byte_valid = 1'b1;
                n = n + 3'd1;
            end
        end

        // end result and status
        trk_end = d.s;
        if (!trk_end.past_lead) begin
            st = updv_pkg::ST_EMPTY_KEY;
        end
        else begin
            if (trk_end.seg_len != 2'd0)
                trk_end = close_seg(trk_end);
            if (trk_end.first_err != updv_pkg::ST_OK)
                st = trk_end.first_err;
            else if (trk_end.saw_null)
                st = updv_pkg::ST_NULL_BYTE;
            else
                st = updv_pkg::ST_OK;
        end
        if (item.last_byte) begin
            res[n[1:0]].end_of_key = 1'b1;
            res[n[1:0]].status     = st;
            n = n + 3'd1;
        end
        res_cnt = n;
    end

    // track state follows the deliveries; the last byte starts a new target
    always_comb
    begin
        nxt     = ctl;
        nxt.trk = d.s;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/url_path_decode_validate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// url_path_decode_validate
// Request-target path decoder and object-key validator.
// ----------------------------------------------------------------------------
// Usage
//   in_valid/in_stall/in_data carry the request target one byte per
//   transfer, last_byte set on its final byte. out_valid/out_stall/out_data
//   carry decoded key bytes (byte_valid) and, after the last byte, one
//   end result (end_of_key) with the key status.
//   cfg_wr_en/cfg_wr_data write skip_len, the route prefix length; a new
//   value applies from the next target.
// Latency and throughput
//   A byte is decoded in the cycle it is transferred; its results appear
//   from the next cycle, one per cycle while out_stall is low, out of a
//   four-entry result buffer. A byte that gives at most one result can be
//   followed by the next byte in the next cycle when out_stall is low. A
//   byte giving more (a broken escape or the last byte, up to four) holds
//   in_stall while the buffer drains one result per cycle, up to its last.
// Reset and stall
//   rst_n clears skip_len, the per-target control state and the result count.
//   While out_stall is high the shown result holds and no byte is taken
//   as long as any result is still waiting.
// ----------------------------------------------------------------------------
module url_path_decode_validate (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            cfg_wr_en,
    input  wire logic [7:0]      cfg_wr_data,
    input  wire logic            in_valid,
    output      logic            in_stall,
    input  wire updv_pkg::item_t in_data,
    output      logic            out_valid,
    input  wire logic            out_stall,
    output      updv_pkg::res_t  out_data
);

    logic [7:0]     skip_len_reg;
    updv_pkg::pst_t state_reg;
    updv_pkg::pst_t state_next;
    logic [7:0]     pend_hex_reg;
    logic [7:0]     pend_hex_next;
    updv_pkg::res_t buf_reg [updv_pkg::RES_MAX];
    updv_pkg::res_t res     [updv_pkg::RES_MAX];
    logic [2:0]     res_cnt;
    logic [2:0]     cnt_reg;
    logic [2:0]     cnt_next;
    logic [1:0]     head_reg;
    logic [1:0]     head_next;
    logic           in_xfer;
    logic           out_xfer;

    // per-byte decode
    updv_step u_step (
        .item          (in_data),
        .cur           (state_reg),
        .pend_hex      (pend_hex_reg),
        .skip_len      (skip_len_reg),
        .nxt           (state_next),
        .pend_hex_next (pend_hex_next),
        .res           (res),
        .res_cnt       (res_cnt)
    );

    // handshakes: a new byte only when the buffer is or becomes empty
    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = buf_reg[head_reg];
    assign out_xfer  = out_valid && !out_stall;
    assign in_stall  = !((cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && out_xfer));
    assign in_xfer   = in_valid && !in_stall;

    // buffer fill and drain
    always_comb
    begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        if (in_xfer) begin
            cnt_next  = res_cnt;
            head_next = 2'd0;
        end
        else if (out_xfer) begin
            cnt_next  = cnt_reg - 3'd1;
            head_next = head_reg + 2'd1;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_len_reg <= 8'd0;
        else if (cfg_wr_en)
            skip_len_reg <= cfg_wr_data;
    end

    // per-target state, back to its start value after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= updv_pkg::PST_RESET;
        else if (in_xfer)
            state_reg <= in_data.last_byte ? updv_pkg::PST_RESET : state_next;
    end

    // buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 3'd0;
            head_reg <= 2'd0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            head_reg <= head_next;
        end
    end

    // payload: held hex digit and result buffer
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            pend_hex_reg <= pend_hex_next;
            for (int i = 0; i < updv_pkg::RES_MAX; i++)
                buf_reg[i] <= res[i];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/updv_chk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// updv_chk
// Port-level checks of the path decoder's result stream.
// ----------------------------------------------------------------------------
module updv_chk (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            out_valid,
    input wire logic            out_stall,
    input wire updv_pkg::res_t  out_data
);

    // every result is either a key byte or the end result
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.byte_valid ^ out_data.end_of_key))
        else $error("result is neither key byte nor end result");

    // key bytes carry no status
    a_key_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.byte_valid) |->
            (out_data.status == updv_pkg::ST_OK))
        else $error("key byte with non-zero status");

    // end result carries a zero byte and a defined status code
    a_end_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.end_of_key) |->
            ((out_data.key_byte == 8'd0) &&
             ((out_data.status == updv_pkg::ST_OK) ||
              (out_data.status == updv_pkg::ST_EMPTY_KEY) ||
              (out_data.status == updv_pkg::ST_EMPTY_SEG) ||
              (out_data.status == updv_pkg::ST_DOT_SEG) ||
              (out_data.status == updv_pkg::ST_NULL_BYTE))))
        else $error("malformed end result");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed");

endmodule

bind url_path_decode_validate updv_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire

FILE: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Regression for the request path decoder and object-key checker: byte
// transfers go in under random idling and output back-pressure, and a
// behavioural model decodes each accepted byte into the key bytes and end
// status that must come out, compared field by field in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int IDLE_PCT      = 21;
    localparam int ITEM_TARGET   = 460;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef logic [7:0] path_t [$];

    logic            clk = 1'b0;
    logic            rst_n;
    logic            cfg_wr_en;
    logic [7:0]      cfg_wr_data;
    logic            in_valid;
    logic            in_stall;
    updv_pkg::item_t in_data;
    logic            out_valid;
    logic            out_stall;
    updv_pkg::res_t  out_data;

    // run control
    int errors     = 0;
    int items_sent = 0;
    int cycles     = 0;
    int hold_reqs  = 0;
    bit gaps_on    = 1'b1;
    bit stalls_on  = 1'b1;

    // decoder model state
    logic [7:0]        skip_len_m;
    logic              at_start;
    logic [7:0]        skip_rem;
    logic              in_query;
    logic [1:0]        pend_cnt;
    logic [7:0]        pend_byte [2];
    logic              past_lead;
    logic [1:0]        seg_len;
    logic              all_dots;
    updv_pkg::status_t first_err;
    logic              saw_null;
    updv_pkg::res_t    key_q [$];

    url_path_decode_validate dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // decoder model
    // ------------------------------------------------------------------------

    function automatic void clear_target_state();
        at_start  = 1'b1;
        skip_rem  = 8'd0;
        in_query  = 1'b0;
        pend_cnt  = updv_pkg::PEND_NONE;
        past_lead = 1'b0;
        seg_len   = 2'd0;
        all_dots  = 1'b1;
        first_err = updv_pkg::ST_OK;
        saw_null  = 1'b0;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= updv_pkg::CH_ZERO && c <= updv_pkg::CH_NINE) ||
               (c >= updv_pkg::CH_LA && c <= updv_pkg::CH_LF) ||
               (c >= updv_pkg::CH_UA && c <= updv_pkg::CH_UF);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c >= updv_pkg::CH_ZERO && c <= updv_pkg::CH_NINE)
            return 4'(c - updv_pkg::CH_ZERO);
        if (c >= updv_pkg::CH_LA && c <= updv_pkg::CH_LF)
            return 4'(c - updv_pkg::CH_LA + updv_pkg::HEX_TEN);
        return 4'(c - updv_pkg::CH_UA + updv_pkg::HEX_TEN);
    endfunction

    // first failing segment decides the status
    function automatic void close_segment();
        if (first_err == updv_pkg::ST_OK)
        begin
            if (seg_len == 2'd0)
                first_err = updv_pkg::ST_EMPTY_SEG;
            else if (all_dots && seg_len <= 2'd2)
                first_err = updv_pkg::ST_DOT_SEG;
        end
        seg_len  = 2'd0;
        all_dots = 1'b1;
    endfunction

    // one decoded path byte: strip leading slashes, track segments, emit
    function automatic void emit_key_byte(input logic [7:0] b);
        updv_pkg::res_t r;
        if (!past_lead)
        begin
            if (b == updv_pkg::CH_SLASH)
                return;
            past_lead = 1'b1;
        end
        if (b == updv_pkg::CH_SLASH)
            close_segment();
        else
        begin
            if (seg_len != updv_pkg::SEG_LEN_MAX)
                seg_len = seg_len + 2'd1;
            if (b != updv_pkg::CH_DOT)
                all_dots = 1'b0;
            if (b == updv_pkg::CH_NUL)
                saw_null = 1'b1;
        end
        r = '{key_byte: b, byte_valid: 1'b1, end_of_key: 1'b0,
              status: updv_pkg::ST_OK};
        key_q = {key_q, r};
    endfunction

    function automatic void take_plain(input logic [7:0] c);
        if (c == updv_pkg::CH_PERCENT)
        begin
            pend_byte[0] = c;
            pend_cnt     = updv_pkg::PEND_PCT;
        end
        else
            emit_key_byte(c);
    endfunction

    // an open escape goes out as the literal bytes it held
    function automatic void flush_escape();
        logic [1:0] n;
        n        = pend_cnt;
        pend_cnt = updv_pkg::PEND_NONE;
        if (n != updv_pkg::PEND_NONE)
            emit_key_byte(pend_byte[0]);
        if (n == updv_pkg::PEND_HEX)
            emit_key_byte(pend_byte[1]);
    endfunction

    // results caused by one accepted target byte
    function automatic void decode_byte(input logic [7:0] c, input logic last);
        updv_pkg::status_t st;
        updv_pkg::res_t    r;
        if (at_start)
        begin
            skip_rem = skip_len_m;
            at_start = 1'b0;
        end
        if (!in_query)
        begin
            if (c == updv_pkg::CH_QUESTION)
            begin
                in_query = 1'b1;
                flush_escape();
            end
            else if (skip_rem != 8'd0)
                skip_rem = skip_rem - 8'd1;
            else
            begin
                case (pend_cnt)
                    updv_pkg::PEND_NONE:
                        take_plain(c);
                    updv_pkg::PEND_PCT:
                        if (is_hex(c))
                        begin
                            pend_byte[1] = c;
                            pend_cnt     = updv_pkg::PEND_HEX;
                        end
                        else
                        begin
                            pend_cnt = updv_pkg::PEND_NONE;
                            emit_key_byte(pend_byte[0]);
                            take_plain(c);
                        end
                    default:
                    begin
                        pend_cnt = updv_pkg::PEND_NONE;
                        if (is_hex(c))
                            emit_key_byte({hex_nibble(pend_byte[1]), hex_nibble(c)});
                        else
                        begin
                            emit_key_byte(pend_byte[0]);
                            emit_key_byte(pend_byte[1]);
                            take_plain(c);
                        end
                    end
                endcase
            end
        end
        if (last)
        begin
            flush_escape();
            if (!past_lead)
                st = updv_pkg::ST_EMPTY_KEY;
            else
            begin
                if (seg_len != 2'd0)
                    close_segment();
                if (first_err != updv_pkg::ST_OK)
                    st = first_err;
                else if (saw_null)
                    st = updv_pkg::ST_NULL_BYTE;
                else
                    st = updv_pkg::ST_OK;
            end
            r = '{key_byte: 8'h00, byte_valid: 1'b0, end_of_key: 1'b1, status: st};
            key_q = {key_q, r};
            clear_target_state();
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    // compare each output transfer with the oldest outstanding result
    always @(posedge clk)
    begin : check_results
        updv_pkg::res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (key_q.size() == 0)
            begin
                $error("unexpected result: key_byte %0h end_of_key %0b status %0d",
                       out_data.key_byte, out_data.end_of_key, out_data.status);
                errors++;
            end
            else
            begin
                want = key_q.pop_front();
                check_field("key_byte", want.key_byte, out_data.key_byte);
                check_field("byte_valid", 8'(want.byte_valid), 8'(out_data.byte_valid));
                check_field("end_of_key", 8'(want.end_of_key), 8'(out_data.end_of_key));
                check_field("status", 8'(want.status), 8'(out_data.status));
            end
        end
    end

    // output back-pressure: random stalls, or a long hold when requested
    initial
    begin : receiver
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_seen)
            begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= stalls_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("url_path_decode_validate regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    // one byte transfer, with an optional idle gap in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{target_byte: b, last_byte: last};
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_byte(b, last);
        items_sent++;
    endtask

    task automatic send_path(input path_t p);
        foreach (p[i])
            send_byte(p[i], i == p.size() - 1);
    endtask

    // stop sending and let every outstanding result come out
    task automatic wait_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (key_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_skip_len(input logic [7:0] v);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        skip_len_m  = v;
    endtask

    function automatic logic [7:0] rand_hex_digit();
        int d;
        d = $urandom_range(21);
        if (d < 10)
            return updv_pkg::CH_ZERO + 8'(d);
        if (d < 16)
            return updv_pkg::CH_LA + 8'(d - 10);
        return updv_pkg::CH_UA + 8'(d - 16);
    endfunction

    function automatic logic [7:0] rand_letter();
        return updv_pkg::CH_LA + 8'($urandom_range(25));
    endfunction

    // mostly well-formed paths behind a prefix, some plain noise
    function automatic path_t random_path(input int skip);
        path_t p;
        int    n;
        int    r;
        if ($urandom_range(9) == 0)
        begin
            n = $urandom_range(1, 6);
            repeat (n) p = {p, 8'($urandom_range(255))};
            return p;
        end
        if (skip <= 8)
            repeat (skip)
                p = {p, ($urandom_range(19) == 0) ? updv_pkg::CH_QUESTION : rand_letter()};
        n = $urandom_range(1, 8);
        repeat (n)
        begin
            r = $urandom_range(99);
            if (r < 33)
                p = {p, rand_letter()};
            else if (r < 48)
                p = {p, updv_pkg::CH_SLASH};
            else if (r < 58)
                p = {p, updv_pkg::CH_DOT};
            else if (r < 66)
                p = {p, updv_pkg::CH_PERCENT, rand_hex_digit(), rand_hex_digit()};
            else if (r < 74)
            begin
                // encoded dot, slash or null
                p = {p, updv_pkg::CH_PERCENT};
                case ($urandom_range(2))
                    0: p = {p, updv_pkg::CH_ZERO + 8'd2};
                    1: p = {p, updv_pkg::CH_ZERO + 8'd2};
                    default: p = {p, updv_pkg::CH_ZERO};
                endcase
                case ($urandom_range(4))
                    0: p = {p, 8'h65};           // 'e'
                    1: p = {p, 8'h45};           // 'E'
                    2: p = {p, updv_pkg::CH_LF};
                    3: p = {p, updv_pkg::CH_UF};
                    default: p = {p, updv_pkg::CH_ZERO};
                endcase
            end
            else if (r < 80)
            begin
                // broken escape
                p = {p, updv_pkg::CH_PERCENT};
                if ($urandom_range(1))
                    p = {p, rand_hex_digit()};
                p = {p, ($urandom_range(1) == 0) ? 8'h67 : updv_pkg::CH_PERCENT};
            end
            else if (r < 84)
                p = {p, updv_pkg::CH_QUESTION};
            else if (r < 89)
                p = {p, updv_pkg::CH_NUL};
            else
                p = {p, 8'($urandom_range(255))};
        end
        // escape left open at the last byte
        if ($urandom_range(9) == 0)
        begin
            p = {p, updv_pkg::CH_PERCENT};
            if ($urandom_range(1))
                p = {p, rand_hex_digit()};
        end
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // leading slash stripped, top byte value, single trailing slash
    task automatic test_slashes();
        path_t p;
        set_skip_len(8'd0);
        p = {updv_pkg::CH_SLASH, 8'hFF, updv_pkg::CH_SLASH};
        send_path(p);
    endtask

    // decoded escape, '%' then non-hex, '%' digit then non-hex on the last byte
    task automatic test_escapes();
        path_t p;
        p = {updv_pkg::CH_PERCENT, 8'h34, updv_pkg::CH_LA, updv_pkg::CH_PERCENT, 8'h67,
             updv_pkg::CH_PERCENT, 8'h34, 8'h5A};
        send_path(p);
    endtask

    // decoded null byte, and a ".." segment built from an escape
    task automatic test_null_and_dots();
        path_t p;
        p = {updv_pkg::CH_PERCENT, updv_pkg::CH_ZERO, updv_pkg::CH_ZERO};
        send_path(p);
        p = {updv_pkg::CH_DOT, updv_pkg::CH_PERCENT, updv_pkg::CH_ZERO + 8'd2, 8'h45};
        send_path(p);
    endtask

    // empty segment, escape cut short by '?', query ignored
    task automatic test_empty_segment();
        path_t p;
        p = {updv_pkg::CH_LA, updv_pkg::CH_SLASH, updv_pkg::CH_SLASH,
             updv_pkg::CH_PERCENT, 8'h34, updv_pkg::CH_QUESTION, 8'h62};
        send_path(p);
    endtask

    // target shorter than the prefix, '?' inside the prefix
    task automatic test_prefix_skip();
        path_t p;
        set_skip_len(8'd255);
        send_byte(updv_pkg::CH_NUL, 1'b1);
        set_skip_len(8'd2);
        p = {updv_pkg::CH_LA, updv_pkg::CH_QUESTION};
        send_path(p);
    endtask

    // a new prefix length only applies from the next target
    task automatic test_late_config();
        send_byte(8'h62, 1'b0);
        set_skip_len(8'd0);
        send_byte(8'h63, 1'b1);
        send_byte(updv_pkg::CH_NUL, 1'b1);
    endtask

    // hold the output off while bytes keep coming so the input stalls
    task automatic test_backpressure();
        path_t p;
        wait_drain();
        gaps_on = 1'b0;
        for (int i = 0; i < 40; i++)
            p = {p, (i % 7 == 6) ? updv_pkg::CH_SLASH : updv_pkg::CH_LA + 8'(i % 26)};
        hold_reqs <= hold_reqs + 1;
        send_path(p);
        wait_drain();
        gaps_on = 1'b1;
    endtask

    // random targets over several prefix lengths, first phase without idling
    task automatic test_random_targets();
        int  skip;
        int  targets;
        int  phase;
        bit  quiet;
        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(5))
                0: skip = 255;
                1: skip = $urandom_range(1, 6);
                default: skip = 0;
            endcase
            if (phase == 1)
                skip = 0;
            set_skip_len(8'(skip));
            quiet     = (phase == 0) || ($urandom_range(4) == 0);
            gaps_on   = !quiet;
            stalls_on = !quiet;
            targets   = (skip == 255) ? 2 : $urandom_range(3, 10);
            repeat (targets)
                if (items_sent < ITEM_TARGET)
                    send_path(random_path(skip));
            phase++;
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 8'd0;
        in_valid    <= 1'b0;
        in_data     <= '0;
        skip_len_m   = 8'd0;
        pend_byte[0] = 8'd0;
        pend_byte[1] = 8'd0;
        clear_target_state();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_slashes();
        test_escapes();
        test_null_and_dots();
        test_empty_segment();
        test_prefix_skip();
        test_late_config();
        test_backpressure();
        test_random_targets();

        wait_drain();
        if (errors == 0)
            $display("url_path_decode_validate regression: pass");
        else
            $display("url_path_decode_validate regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/updv_pkg.sv
hw/rtl/updv_step.sv
hw/rtl/url_path_decode_validate.sv
hw/rtl/updv_chk.sv
dv/tb.sv
